[rtl/cdq_pkg.sv]
package cdq_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int VALUE_W   = 32;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = 5;
  localparam int CMD_W     = 3;
  localparam int ADDR_W    = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CAP_W'(1);
    end else if (v > CAP_MAX) begin
      r = CAP_MAX;
    end
    return r;
  endfunction

endpackage

[rtl/cdq_req_if.sv]
interface cdq_req_if
  import cdq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink (input valid, input command, input item_value, output ready);
endinterface

[rtl/cdq_rsp_if.sv]
interface cdq_rsp_if
  import cdq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] rear_value;
  logic                      is_empty;
  logic                      is_full;

  modport source (
    output valid, output accepted, output front_value, output rear_value,
    output is_empty, output is_full, input ready
  );
  modport sink (
    input valid, input accepted, input front_value, input rear_value,
    input is_empty, input is_full, output ready
  );
endinterface

[rtl/cdq_ram.sv]
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/circular_deque_unit.sv]
// channel  dir  payload                                                 transfer
// req      in   command, item_value                                     valid & ready
// rsp      out  accepted, front_value, rear_value, is_empty, is_full    valid & ready
// cfg      in   apb write of capacity at byte address 0                 psel & penable & pwrite
//
// per item: the accept cycle updates indices, writes the entry ram and issues
// the front and rear reads; the read state loads the registered ram data into
// the response register when it can. ram writes forward into a same-entry read.
// synchronous reset empties the deque and sets capacity to 16; no ram clear.
// req stalls while an item is in flight or its response cannot be loaded.
module circular_deque_unit
  import cdq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  cdq_req_if.sink            req,
  cdq_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state;
  logic [CAP_W-1:0] capacity;
  logic [IDX_W-1:0] front_index, front_index_next;
  logic [IDX_W-1:0] rear_index, rear_index_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;

  logic               acc_q, empty_q, full_q, fwd_front, fwd_rear;
  logic [VALUE_W-1:0] wdata_q;

  logic               fire, cfg_write, can_load;
  logic               full, empty, acc, we;
  logic [IDX_W-1:0]   waddr, last_index, cap_m1;
  logic [IDX_W-1:0]   front_dec, front_inc, rear_dec, rear_inc;
  logic [CAP_W-1:0]   cap_m1_w;
  logic [VALUE_W-1:0] ram_front, ram_rear, wdata;

  assign fire      = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;
  assign can_load  = !rsp.valid || rsp.ready;

  assign cap_m1_w  = capacity - CAP_W'(1);
  assign cap_m1    = cap_m1_w[IDX_W-1:0];
  assign front_dec = (front_index == '0) ? cap_m1 : front_index - IDX_W'(1);
  assign front_inc = (front_index == cap_m1) ? '0 : front_index + IDX_W'(1);
  assign rear_dec  = (rear_index == '0) ? cap_m1 : rear_index - IDX_W'(1);
  assign rear_inc  = (rear_index == cap_m1) ? '0 : rear_index + IDX_W'(1);
  assign full      = (entry_count >= CNT_W'(capacity));
  assign empty     = (entry_count == '0);
  assign wdata     = req.item_value;

  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    entry_count_next = entry_count;
    acc              = 1'b0;
    we               = 1'b0;
    waddr            = front_dec;
    if (fire) begin
      case (req.command)
        CMD_PUSH_FRONT: begin
          if (!full) begin
            front_index_next = front_dec;
            entry_count_next = entry_count + CNT_W'(1);
            we               = 1'b1;
            waddr            = front_dec;
            acc              = 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (!full) begin
            rear_index_next  = rear_inc;
            entry_count_next = entry_count + CNT_W'(1);
            we               = 1'b1;
            waddr            = rear_index;
            acc              = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (!empty) begin
            front_index_next = front_inc;
            entry_count_next = entry_count - CNT_W'(1);
            acc              = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (!empty) begin
            rear_index_next  = rear_dec;
            entry_count_next = entry_count - CNT_W'(1);
            acc              = 1'b1;
          end
        end
        CMD_QUERY: acc = 1'b1;
        default: acc = 1'b0;
      endcase
    end
    last_index = (rear_index_next == '0) ? cap_m1 : rear_index_next - IDX_W'(1);
  end

  cdq_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DEPTH)) front_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (front_index_next),
    .rdata (ram_front)
  );

  cdq_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_DEPTH)) rear_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (last_index),
    .rdata (ram_rear)
  );

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_q     <= acc;
      empty_q   <= (entry_count_next == '0);
      full_q    <= (entry_count_next >= CNT_W'(capacity));
      fwd_front <= we && (waddr == front_index_next);
      fwd_rear  <= we && (waddr == last_index);
      wdata_q   <= wdata;
    end
    if (state == ST_READ && can_load) begin
      rsp.accepted    <= acc_q;
      rsp.is_empty    <= empty_q;
      rsp.is_full     <= full_q;
      rsp.front_value <= empty_q ? '1 : (fwd_front ? wdata_q : ram_front);
      rsp.rear_value  <= empty_q ? '1 : (fwd_rear ? wdata_q : ram_rear);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rsp.valid   <= 1'b0;
      capacity    <= clamp_cap(CAP_RESET);
      front_index <= '0;
      rear_index  <= '0;
      entry_count <= '0;
    end else begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      entry_count <= entry_count_next;
      unique case (state)
        ST_IDLE: begin
          if (fire) begin
            state <= ST_READ;
          end
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
          end
        end
        ST_READ: begin
          if (can_load) begin
            rsp.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_write && paddr[2] == REG_CAPACITY) begin
        capacity    <= clamp_cap(pwdata[CAP_W-1:0]);
        front_index <= '0;
        rear_index  <= '0;
        entry_count <= '0;
      end
    end
  end
endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cdq_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 120;
  localparam int ROUND_ITEMS  = 40;

  localparam logic [CMD_W-1:0]  CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_MID   = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_LAST  = 3'd7;
  localparam logic [ADDR_W-1:0] CAP_ADDR         = ADDR_W'(4 * REG_CAPACITY);

  typedef struct packed {
    logic               accepted;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } deque_view_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque_unit uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // deque mirror
  logic [VALUE_W-1:0] slots [MAX_DEPTH];
  int unsigned        head_pos;
  int unsigned        tail_pos;
  int unsigned        fill_level;
  int unsigned        cap_now;

  deque_view_t expected_views [$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        holding;
  event        long_hold;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || holding) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    holding <= 1'b0;
    forever begin
      @(long_hold);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  function automatic deque_view_t apply_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
    deque_view_t view;
    logic        was_full;
    logic        was_empty;
    was_full  = (fill_level >= cap_now);
    was_empty = (fill_level == 0);
    head_pos  = head_pos % cap_now;
    tail_pos  = tail_pos % cap_now;
    view      = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (!was_full) begin
          head_pos = (head_pos + cap_now - 1) % cap_now;
          slots[head_pos] = val;
          fill_level++;
          view.accepted = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (!was_full) begin
          slots[tail_pos] = val;
          tail_pos = (tail_pos + 1) % cap_now;
          fill_level++;
          view.accepted = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!was_empty) begin
          head_pos = (head_pos + 1) % cap_now;
          fill_level--;
          view.accepted = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (!was_empty) begin
          tail_pos = (tail_pos + cap_now - 1) % cap_now;
          fill_level--;
          view.accepted = 1'b1;
        end
      end
      CMD_QUERY: begin
        view.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    if (fill_level == 0) begin
      view.front_value = '1;
      view.rear_value  = '1;
    end else begin
      view.front_value = slots[head_pos];
      view.rear_value  = slots[(tail_pos + cap_now - 1) % cap_now];
    end
    view.is_empty = (fill_level == 0);
    view.is_full  = (fill_level >= cap_now);
    return view;
  endfunction

  task automatic note_field(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_views.size() == 0) begin
        errors++;
        $display("%0t: response transfer with nothing outstanding", $time);
      end else begin
        want = expected_views.pop_front();
        note_field("accepted", VALUE_W'(want.accepted), VALUE_W'(rsp_ch.accepted));
        note_field("front_value", want.front_value, rsp_ch.front_value);
        note_field("rear_value", want.rear_value, rsp_ch.rear_value);
        note_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(rsp_ch.is_empty));
        note_field("is_full", VALUE_W'(want.is_full), VALUE_W'(rsp_ch.is_full));
      end
    end
  end

  // entered and left at a rising edge
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.item_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    expected_views.push_back(apply_command(cmd, val));
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (cap == 0) cap_now = 1;
    else if (cap > MAX_DEPTH) cap_now = MAX_DEPTH;
    else cap_now = cap;
    head_pos   = 0;
    tail_pos   = 0;
    fill_level = 0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return {1'b0, {(VALUE_W-1){1'b1}}};
      1: return {1'b1, {(VALUE_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    if (roll < 94) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    if (roll < 98) return CMD_QUERY;
    return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
  endfunction

  task automatic test_directed_ops;
    send_item(CMD_QUERY, '0);
    send_item(CMD_POP_FRONT, '1);
    send_item(CMD_POP_BACK, '1);
    send_item(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_item(CMD_PUSH_BACK, 32'h8000_0000);
    send_item(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_item(CMD_PUSH_BACK, 32'h0000_0000);
    send_item(CMD_QUERY, 32'h5a5a_a5a5);
    send_item(CMD_UNUSED_FIRST, 32'h1234_5678);
    send_item(CMD_UNUSED_MID, 32'h1);
    send_item(CMD_UNUSED_LAST, 32'h2);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_BACK, '0);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_POP_BACK, '0);
    send_item(CMD_POP_FRONT, '0);
  endtask

  task automatic test_capacity_edges;
    set_capacity(CAP_W'(1));
    send_item(CMD_PUSH_BACK, 32'hdead_beef);
    send_item(CMD_PUSH_FRONT, 32'h0bad_f00d);
    send_item(CMD_POP_FRONT, '0);
    send_item(CMD_PUSH_FRONT, 32'h8000_0001);
    set_capacity(CAP_W'(0));
    send_item(CMD_QUERY, '0);
    send_item(CMD_PUSH_BACK, 32'h7fff_fffe);
    send_item(CMD_PUSH_BACK, 32'h1);
    set_capacity(CAP_W'(31));
    send_item(CMD_QUERY, '0);
    set_capacity(CAP_W'(16));
  endtask

  task automatic test_backpressure;
    set_capacity(CAP_W'(16));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> long_hold;
    repeat (30) send_item(pick_command(70), pick_value());
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int rounds);
    int push_pct;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (rounds) begin
      if ($urandom_range(1)) begin
        case ($urandom_range(3))
          0: set_capacity(CAP_W'(1));
          1: set_capacity(CAP_W'(16));
          2: set_capacity(CAP_W'(0));
          default: set_capacity(CAP_W'(31));
        endcase
      end else begin
        set_capacity(CAP_W'($urandom_range(31)));
      end
      push_pct = 70 + $urandom_range(20);
      repeat (ROUND_ITEMS / 2) send_item(pick_command(push_pct), pick_value());
      push_pct = $urandom_range(10, 30);
      repeat (ROUND_ITEMS / 2) send_item(pick_command(push_pct), pick_value());
    end
  endtask

  initial begin
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    head_pos          = 0;
    tail_pos          = 0;
    fill_level        = 0;
    cap_now           = MAX_DEPTH;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_QUERY;
    req_ch.item_value <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_capacity_edges();
    test_backpressure();
    test_random_traffic(0, 0, 3);
    test_random_traffic(48, 0, 3);
    test_random_traffic(0, 48, 3);
    test_random_traffic(33, 33, 3);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_views.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cdq_pkg.sv
rtl/cdq_req_if.sv
rtl/cdq_rsp_if.sv
rtl/cdq_ram.sv
rtl/circular_deque_unit.sv
tb/tb.sv
